FILE: rtl/cv2d_pkg.sv
`default_nettype none

package cv2d_pkg;

  // Beat kinds on the input channel.
  typedef enum logic {
    KIND_WEIGHT = 1'b0,
    KIND_PIXEL  = 1'b1
  } cv2d_kind_t;

  // Fixed field widths of the two channels.
  localparam int IDX_W = 4;
  localparam int WV_W  = 8;
  localparam int PIX_W = 8;
  localparam int VAL_W = 8;
  localparam int POS_W = 5;

  // Taps folded into one accumulator stage.
  localparam int MAC_STEP = 5;

  // Position and flags that travel alongside one window through the pipe.
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } cv2d_ctl_t;

  // One finished result.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } cv2d_res_t;

endpackage

`default_nettype wire

FILE: rtl/cv2d_if.sv
`default_nettype none

interface cv2d_in_if;
  import cv2d_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [IDX_W-1:0]       weight_index;
  logic signed [WV_W-1:0] weight_value;
  logic [PIX_W-1:0]       pixel;

  modport source (output valid, kind, weight_index, weight_value, pixel, input ready);
  modport sink (input valid, kind, weight_index, weight_value, pixel, output ready);
endinterface

interface cv2d_out_if;
  import cv2d_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic                    last;

  modport source (output valid, out_value, out_row, out_col, last, input ready);
  modport sink (input valid, out_value, out_row, out_col, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/cv2d_line_buf.sv
`default_nettype none

module cv2d_line_buf #(
  parameter int IMG_WIDTH  = 32,
  parameter int IMG_HEIGHT = 32,
  parameter int KERNEL     = 3,
  parameter int PXW        = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pix_take,
  input  logic [PXW-1:0]                    pixel,
  output logic                              emit,
  output logic [KERNEL*KERNEL-1:0][PXW-1:0] win,
  output cv2d_pkg::cv2d_ctl_t               ctl
);
  import cv2d_pkg::*;

  localparam int TAPS = KERNEL * KERNEL;
  localparam int CW   = $clog2(IMG_WIDTH);
  localparam int RW   = $clog2(IMG_HEIGHT);

  logic [CW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic                         col_end, row_end;
  logic [KERNEL-1:0][PXW-1:0]   newcol;
  logic [TAPS-1:0][PXW-1:0]     win_r, win_nxt;
  cv2d_ctl_t                    ctl_r;

  assign col_end = (col_r == CW'(IMG_WIDTH - 1));
  assign row_end = (row_r == RW'(IMG_HEIGHT - 1));
  assign emit    = (32'(row_r) >= 32'(KERNEL - 1)) && (32'(col_r) >= 32'(KERNEL - 1));

  always_comb begin
    col_nxt = col_end ? '0 : col_r + CW'(1);
    row_nxt = row_r;
    if (col_end) begin
      row_nxt = row_end ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (pix_take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Each line memory word holds one column of the previous KERNEL-1 rows,
  // oldest row in the low slot. The word for the next column is fetched as
  // soon as a pixel is taken, so it is registered before the next pixel.
  if (KERNEL > 1) begin : g_lmem
    localparam int LBW = (KERNEL - 1) * PXW;

    logic [LBW-1:0] lmem [IMG_WIDTH];
    logic [LBW-1:0] rd_r;
    logic [LBW-1:0] wr_word;
    logic [CW-1:0]  rd_addr;

    assign rd_addr = pix_take ? col_nxt : col_r;
    assign wr_word = LBW'({pixel, rd_r} >> PXW);
    assign newcol  = {pixel, rd_r};

    always_ff @(posedge clk) begin
      if (pix_take) begin
        lmem[col_r] <= wr_word;
      end
      rd_r <= lmem[rd_addr];
    end
  end else begin : g_nomem
    assign newcol = pixel;
  end

  // Window shifts one column left per pixel; the new column enters on the right.
  always_comb begin
    for (int kr = 0; kr < KERNEL; kr++) begin
      for (int kc = 0; kc < KERNEL; kc++) begin
        if (kc < KERNEL - 1) begin
          win_nxt[kr*KERNEL+kc] = win_r[kr*KERNEL+kc+1];
        end else begin
          win_nxt[kr*KERNEL+kc] = newcol[kr];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= pix_take && emit;
      ctl_r.row   <= POS_W'(row_r - RW'(KERNEL - 1));
      ctl_r.col   <= POS_W'(col_r - CW'(KERNEL - 1));
      ctl_r.last  <= row_end && col_end;
    end
  end

  assign win = win_r;
  assign ctl = ctl_r;

endmodule

`default_nettype wire

FILE: rtl/cv2d_mac.sv
`default_nettype none

module cv2d_mac #(
  parameter int KERNEL = 3,
  parameter int PXW    = 8,
  parameter int WW     = 8,
  parameter int SH_R   = 5,
  parameter int SH_L   = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  w_take,
  input  logic [cv2d_pkg::IDX_W-1:0]            w_index,
  input  logic [WW-1:0]                         w_value,
  input  logic [KERNEL*KERNEL-1:0][PXW-1:0]     win,
  input  cv2d_pkg::cv2d_ctl_t                   ctl_in,
  output logic [cv2d_pkg::VAL_W-1:0]            acc_out,
  output cv2d_pkg::cv2d_ctl_t                   ctl_out
);
  import cv2d_pkg::*;

  localparam int TAPS = KERNEL * KERNEL;
  localparam int NSTG = (TAPS + MAC_STEP - 1) / MAC_STEP;
  localparam int PRW  = WW + PXW + 1;
  localparam int AW   = VAL_W + SH_R;
  localparam int BW   = PRW + SH_L;
  localparam int SW   = ((AW > BW) ? AW : BW) + 1;
  localparam logic [SW-1:0] FRAC_MASK = (SW'(1) << SH_R) - SW'(1);

  logic [WW-1:0]              w_r [TAPS];
  logic [TAPS-1:0][PRW-1:0]   p_r [NSTG+1];
  cv2d_ctl_t                  ctl_r [NSTG+1];
  logic [VAL_W-1:0]           acc_r [NSTG];

  // One accumulate: add the scaled product, truncate toward zero to an
  // integer, keep the low eight bits.
  function automatic logic [VAL_W-1:0] acc_step(input logic [VAL_W-1:0] acc,
                                                input logic [PRW-1:0]   p);
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] q;
    sum = (SW'(signed'(acc)) <<< SH_R) + (SW'(signed'(p)) <<< SH_L);
    q   = sum >>> SH_R;
    if (sum[SW-1] && ((sum & FRAC_MASK) != '0)) begin
      q = q + SW'(1);
    end
    return q[VAL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    for (int t = 0; t < TAPS; t++) begin
      if (w_take && (32'(w_index) == t)) begin
        w_r[t] <= w_value;
      end
    end
  end

  // Product stage: one multiplier per tap.
  always_ff @(posedge clk) begin
    for (int t = 0; t < TAPS; t++) begin
      p_r[0][t] <= PRW'(signed'(w_r[t])) * PRW'(signed'({1'b0, win[t]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= ctl_in;
    end
  end

  // Accumulator chain, up to MAC_STEP taps per registered stage in tap order.
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [VAL_W-1:0] acc_in;
    logic [VAL_W-1:0] acc_nxt;

    if (s == 0) begin : g_first
      assign acc_in = '0;
    end else begin : g_next
      assign acc_in = acc_r[s-1];
    end

    always_comb begin
      acc_nxt = acc_in;
      for (int k = 0; k < MAC_STEP; k++) begin
        if (s * MAC_STEP + k < TAPS) begin
          acc_nxt = acc_step(acc_nxt, p_r[s][s*MAC_STEP+k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      acc_r[s]   <= acc_nxt;
      p_r[s+1]   <= p_r[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1] <= '0;
      end else begin
        ctl_r[s+1] <= ctl_r[s];
      end
    end
  end

  assign acc_out = acc_r[NSTG-1];
  assign ctl_out = ctl_r[NSTG];

endmodule

`default_nettype wire

FILE: rtl/cv2d_out_fifo.sv
`default_nettype none

module cv2d_out_fifo #(
  parameter int DEPTH = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  output logic                room,
  input  logic                push,
  input  cv2d_pkg::cv2d_res_t push_data,
  cv2d_out_if.source          out_if
);
  import cv2d_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  cv2d_res_t      q_mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0] cnt_r, credit_r;
  logic           pop;

  // A credit is held from the accepted pixel beat until its result leaves,
  // so the queue can never overflow even though the pipe never stalls.
  assign pop  = out_if.valid && out_if.ready;
  assign room = (credit_r < CNW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      credit_r <= credit_r + CNW'(take) - CNW'(pop);
      cnt_r    <= cnt_r + CNW'(push) - CNW'(pop);
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  assign out_if.valid     = (cnt_r != '0);
  assign out_if.out_value = q_mem[rd_ptr_r].value;
  assign out_if.out_row   = q_mem[rd_ptr_r].row;
  assign out_if.out_col   = q_mem[rd_ptr_r].col;
  assign out_if.last      = q_mem[rd_ptr_r].last;

endmodule

`default_nettype wire

FILE: rtl/conv2d_valid_fixed_weights.sv
`default_nettype none

// Streaming 2-D valid-mode convolution with a loadable KERNEL x KERNEL
// weight set. Each input beat is either a weight load (kind = 0, tap index
// in row-major order, signed fixed point with WEIGHT_BITS - WEIGHT_INT_BITS
// fraction bits) or one unsigned pixel (kind = 1) in raster order. Weight
// loads take effect for every pixel beat accepted after them, and any tap
// must be loaded before the first result that uses it. Pixels are counted
// by row and column; once a full window ending at the current pixel is in
// the line memory, one result beat follows carrying the 8-bit wrapped sum,
// the output row and column and a flag on the last output of the image.
// The sum is built in row-major tap order and is truncated toward zero and
// wrapped to eight bits after every tap. After the last pixel of an image
// the position returns to the top left and a new image starts. There is no
// clearing pass after reset: the line memory is always refilled before it
// is read. While in_if.ready is high one beat is taken every clock cycle:
// the line memory has one write and one prefetching read port, and every
// later stage advances each cycle. A result passes the window registers,
// the product stage and the NSTG accumulator stages (the taps in groups of
// five, two stages for a 3x3 kernel), then enters a result queue of NSTG + 4
// entries and is offered on out_if from there;
// in_if.ready drops only when that many results are accepted but not yet
// taken, so a stalled result side stops the input after the queue fills.

module conv2d_valid_fixed_weights #(
  parameter int IMG_WIDTH       = 32,
  parameter int IMG_HEIGHT      = 32,
  parameter int KERNEL          = 3,
  parameter int PIXEL_BITS      = 8,
  parameter int WEIGHT_BITS     = 8,
  parameter int WEIGHT_INT_BITS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  cv2d_in_if.sink    in_if,
  cv2d_out_if.source out_if
);
  import cv2d_pkg::*;

  // Pixel and weight bits that are actually used from the 8-bit fields.
  localparam int PXW  = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int WW   = (WEIGHT_BITS < WV_W) ? WEIGHT_BITS : WV_W;
  // Fraction bits of the weight; a negative count scales products up.
  localparam int FRAC = WEIGHT_BITS - WEIGHT_INT_BITS;
  localparam int SH_R = (FRAC > 0) ? FRAC : 0;
  localparam int SH_L = (FRAC < 0) ? -FRAC : 0;
  localparam int TAPS = KERNEL * KERNEL;
  localparam int NSTG = (TAPS + MAC_STEP - 1) / MAC_STEP;
  localparam int QDEPTH = NSTG + 4;

  logic                       beat;
  logic                       pix_take;
  logic                       w_take;
  logic                       emit;
  logic                       room;
  logic [TAPS-1:0][PXW-1:0]   win;
  cv2d_ctl_t                  win_ctl;
  cv2d_ctl_t                  mac_ctl;
  logic [VAL_W-1:0]           mac_acc;
  cv2d_res_t                  res;

  assign in_if.ready = room;
  assign beat        = in_if.valid && in_if.ready;
  assign pix_take    = beat && (in_if.kind == KIND_PIXEL);
  assign w_take      = beat && (in_if.kind == KIND_WEIGHT);

  // Position counters, line memory and the window registers.
  cv2d_line_buf #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .KERNEL     (KERNEL),
    .PXW        (PXW)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_take (pix_take),
    .pixel    (in_if.pixel[PXW-1:0]),
    .emit     (emit),
    .win      (win),
    .ctl      (win_ctl)
  );

  // Weight registers, the product stage and the accumulator chain.
  cv2d_mac #(
    .KERNEL (KERNEL),
    .PXW    (PXW),
    .WW     (WW),
    .SH_R   (SH_R),
    .SH_L   (SH_L)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .w_take  (w_take),
    .w_index (in_if.weight_index),
    .w_value (in_if.weight_value[WW-1:0]),
    .win     (win),
    .ctl_in  (win_ctl),
    .acc_out (mac_acc),
    .ctl_out (mac_ctl)
  );

  always_comb begin
    res.value = signed'(mac_acc);
    res.row   = mac_ctl.row;
    res.col   = mac_ctl.col;
    res.last  = mac_ctl.last;
  end

  // Result queue; a pixel beat that completes a window reserves one entry.
  cv2d_out_fifo #(
    .DEPTH (QDEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (pix_take && emit),
    .room      (room),
    .push      (mac_ctl.valid),
    .push_data (res),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

FILE: rtl/cv2d_checker.sv
`default_nettype none

module cv2d_checker #(
  parameter int IMG_WIDTH  = 32,
  parameter int IMG_HEIGHT = 32,
  parameter int KERNEL     = 3
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_value,
  input logic [4:0]        out_row,
  input logic [4:0]        out_col,
  input logic              out_last
);

  // Nothing is left queued across a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_value, out_row, out_col, out_last}))
    else $error("stalled result beat changed");

  // The queue is deeper than the pipe, so the input only stops while a
  // result is waiting on the output.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // The last flag only appears on the bottom right output position.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      out_row == 5'(IMG_HEIGHT - KERNEL) && out_col == 5'(IMG_WIDTH - KERNEL))
    else $error("last flag at wrong output position");

endmodule

bind conv2d_valid_fixed_weights cv2d_checker #(
  .IMG_WIDTH  (IMG_WIDTH),
  .IMG_HEIGHT (IMG_HEIGHT),
  .KERNEL     (KERNEL)
) u_cv2d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_value (out_if.out_value),
  .out_row   (out_if.out_row),
  .out_col   (out_if.out_col),
  .out_last  (out_if.last)
);

`default_nettype wire

FILE: tb/sv/tb_conv2d_valid_fixed_weights.sv
`timescale 1ns / 1ps

module tb_conv2d_valid_fixed_weights;
  import cv2d_pkg::*;

  // Geometry and number format of the default build of the block.
  localparam int KERN      = 3;
  localparam int IMG_W     = 32;
  localparam int IMG_H     = 32;
  localparam int FRAC_BITS = 5;
  localparam int TAPS      = KERN * KERN;

  // About two thirds of one image: many full rows of windows, every column
  // position and the row turnover, while keeping the run short.
  localparam int PIX_TOTAL = 660;
  // Neither side idles while the last pixels go through.
  localparam int CALM_TAIL = 150;
  // Pixel count at which the result side holds off for a long stretch.
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 100;
  // Pixel counts after which the sender waits for every result to drain.
  localparam int DRAIN_AT_A = 250;
  localparam int DRAIN_AT_B = 480;

  // One queued input beat, or a marker that makes the sender pause until
  // every expected result has come back.
  typedef struct {
    bit                     pause;
    int unsigned            gap;
    cv2d_kind_t             kind;
    logic [IDX_W-1:0]       idx;
    logic signed [WV_W-1:0] wval;
    logic [PIX_W-1:0]       pix;
  } feed_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  cv2d_in_if  in_if ();
  cv2d_out_if out_if ();

  conv2d_valid_fixed_weights dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #2 clk = ~clk;

  // Beats waiting to be driven, and results the block still owes us.
  feed_beat_t feed_q[$];
  cv2d_res_t  results_due[$];

  // Shadow of the block's state: kernel taps, the last KERN image rows and
  // the raster position of the next pixel.
  logic signed [WV_W-1:0] tap_w[TAPS];
  logic [PIX_W-1:0]       rows_held[KERN][IMG_W];
  int                     pos_row;
  int                     pos_col;

  int  mismatches   = 0;
  int  pix_accepted = 0;
  int  results_seen = 0;
  bit  in_took      = 1'b0;
  bit  long_hold_due = 1'b0;
  bit  calm         = 1'b0;

  // Sum of the window whose top image row sits at top_row and whose right
  // edge is the current column. Taps are added in row-major order; after
  // every add the fixed-point sum is cut to an integer (toward zero, which
  // is what signed division does) and wrapped to eight bits.
  function automatic logic signed [VAL_W-1:0] window_sum(int top_row);
    int                      acc;
    int                      prod;
    int                      full;
    logic signed [VAL_W-1:0] wrapped;
    acc = 0;
    for (int kr = 0; kr < KERN; kr++) begin
      for (int kc = 0; kc < KERN; kc++) begin
        prod = int'(tap_w[kr * KERN + kc]) *
               int'(rows_held[(top_row + kr) % KERN][pos_col + 1 + kc - KERN]);
        full = acc * (1 << FRAC_BITS) + prod;
        wrapped = VAL_W'(full / (1 << FRAC_BITS));
        acc = int'(wrapped);
      end
    end
    return VAL_W'(acc);
  endfunction

  // Applies one accepted beat to the shadow state and queues the result it
  // causes, if any.
  task automatic absorb_beat(logic kind, logic [IDX_W-1:0] idx,
                             logic signed [WV_W-1:0] wval, logic [PIX_W-1:0] pix);
    cv2d_res_t r;
    if (kind == KIND_WEIGHT) begin
      // Indexes past the last tap are dropped without effect.
      if (idx < TAPS) tap_w[idx] = wval;
    end else begin
      rows_held[pos_row % KERN][pos_col] = pix;
      if (pos_row + 1 >= KERN && pos_col + 1 >= KERN) begin
        r.row   = POS_W'(pos_row + 1 - KERN);
        r.col   = POS_W'(pos_col + 1 - KERN);
        r.value = window_sum(pos_row + 1 - KERN);
        r.last  = (pos_row == IMG_H - 1 && pos_col == IMG_W - 1);
        results_due.push_back(r);
      end
      if (pos_col + 1 >= IMG_W) begin
        pos_col = 0;
        pos_row = (pos_row + 1 >= IMG_H) ? 0 : pos_row + 1;
      end else begin
        pos_col++;
      end
    end
  endtask

  // Input side monitor: every accepted beat goes through the predictor at
  // the edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      in_took = 1'b1;
      absorb_beat(in_if.kind, in_if.weight_index, in_if.weight_value, in_if.pixel);
      if (in_if.kind == KIND_PIXEL) begin
        pix_accepted++;
        if (pix_accepted == LONG_HOLD_AT) long_hold_due = 1'b1;
      end
    end
  end

  // Driver. A beat stays on the bus until it is taken; the next one is then
  // put up after its own gap. A pause marker keeps valid low until the
  // block has returned every result it owes.
  feed_beat_t next_beat;
  bit         have_next = 1'b0;
  int         gap_left  = 0;

  always @(negedge clk) begin
    bit waiting;
    bit offer;
    if (rst_n) begin
      waiting = in_if.valid && !in_took;
      in_took = 1'b0;
      calm = (feed_q.size() < CALM_TAIL);
      if (!waiting) begin
        offer = 1'b0;
        if (!have_next && feed_q.size() > 0) begin
          next_beat = feed_q.pop_front();
          have_next = 1'b1;
          gap_left  = next_beat.gap;
        end
        if (have_next && next_beat.pause) begin
          if (results_due.size() == 0) have_next = 1'b0;
        end else if (have_next && gap_left > 0) begin
          gap_left--;
        end else if (have_next) begin
          offer = 1'b1;
          have_next = 1'b0;
          in_if.kind         <= next_beat.kind;
          in_if.weight_index <= next_beat.idx;
          in_if.weight_value <= next_beat.wval;
          in_if.pixel        <= next_beat.pix;
        end
        in_if.valid <= offer;
      end
    end
  end

  // Result side ready. Short random holds, stretches without any, one long
  // hold that lets the block fill up and stall its input, and no holds at
  // all near the end of the run.
  int hold_left = 0;

  always @(negedge clk) begin
    bit rdy;
    if (rst_n) begin
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (!calm && ((results_seen / 150) % 3) != 1 &&
                   $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 9) - 1;
        rdy = 1'b0;
      end
      out_if.ready <= rdy;
    end
  end

  // Result checker: each taken result is matched field by field against
  // the oldest prediction.
  always @(posedge clk) begin
    cv2d_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: value %0d row %0d col %0d last %0b",
                 $time, out_if.out_value, out_if.out_row, out_if.out_col, out_if.last);
      end else begin
        want = results_due.pop_front();
        if (out_if.out_value !== want.value || out_if.out_row !== want.row ||
            out_if.out_col !== want.col || out_if.last !== want.last) begin
          mismatches++;
          $display("%0t: result mismatch: expected value %0d row %0d col %0d last %0b,",
                   $time, want.value, want.row, want.col, want.last);
          $display("%0t:   actual value %0d row %0d col %0d last %0b",
                   $time, out_if.out_value, out_if.out_row, out_if.out_col, out_if.last);
        end
      end
    end
  end

  // Stimulus construction.
  int pix_queued = 0;

  task automatic queue_beat(cv2d_kind_t kind, logic [IDX_W-1:0] idx,
                            logic signed [WV_W-1:0] wval, logic [PIX_W-1:0] pix);
    feed_beat_t b;
    b.pause = 1'b0;
    b.kind  = kind;
    b.idx   = idx;
    b.wval  = wval;
    b.pix   = pix;
    // Random idle bursts, except in every third stretch and in the tail.
    if (pix_queued + CALM_TAIL >= PIX_TOTAL || ((pix_queued / 160) % 3) == 2)
      b.gap = 0;
    else if ($urandom_range(0, 4) == 0)
      b.gap = $urandom_range(1, 9);
    else
      b.gap = 0;
    if (kind == KIND_PIXEL) pix_queued++;
    feed_q.push_back(b);
  endtask

  task automatic queue_drain_pause();
    feed_beat_t b;
    b = '{pause: 1'b1, gap: 0, kind: KIND_WEIGHT, idx: '0, wval: '0, pix: '0};
    feed_q.push_back(b);
  endtask

  // Pixels lean toward the extremes and small values so that large sums,
  // zero windows and heavy wrapping all show up.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PIX_W'($urandom_range(0, 15));
      4:       return PIX_W'($urandom_range(240, 255));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic signed [WV_W-1:0] wv;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_WEIGHT;
    in_if.weight_index = '0;
    in_if.weight_value = '0;
    in_if.pixel        = '0;
    out_if.ready       = 1'b0;
    pos_row = 0;
    pos_col = 0;
    foreach (tap_w[i]) tap_w[i] = '0;

    // Directed opening: every tap written, with the weight extremes, unit
    // values of both signs and alternating bit patterns. Then two loads to
    // indexes past the kernel, which must change nothing, and a few pixels
    // at and near the pixel extremes and around mid-scale.
    queue_beat(KIND_WEIGHT, 0, 8'sd127, '0);
    queue_beat(KIND_WEIGHT, 1, -8'sd128, '0);
    queue_beat(KIND_WEIGHT, 2, 8'sd32, '0);
    queue_beat(KIND_WEIGHT, 3, -8'sd32, '0);
    queue_beat(KIND_WEIGHT, 4, 8'sd1, '0);
    queue_beat(KIND_WEIGHT, 5, -8'sd1, '0);
    queue_beat(KIND_WEIGHT, 6, 8'sd0, '0);
    queue_beat(KIND_WEIGHT, 7, 8'sd85, '0);
    queue_beat(KIND_WEIGHT, 8, -8'sd86, '0);
    queue_beat(KIND_WEIGHT, 9, 8'sd100, '0);
    queue_beat(KIND_WEIGHT, 15, -8'sd100, '0);
    queue_beat(KIND_PIXEL, '0, '0, 8'd255);
    queue_beat(KIND_PIXEL, '0, '0, 8'd0);
    queue_beat(KIND_PIXEL, '0, '0, 8'd255);
    queue_beat(KIND_PIXEL, '0, '0, 8'd0);
    queue_beat(KIND_PIXEL, '0, '0, 8'd128);
    queue_beat(KIND_PIXEL, '0, '0, 8'd1);
    queue_beat(KIND_PIXEL, '0, '0, 8'd254);
    queue_beat(KIND_PIXEL, '0, '0, 8'd127);

    // Random stream: pixels in raster order, now and then a few weight
    // reloads at any index (out-of-range ones included) with any value.
    while (pix_queued < PIX_TOTAL) begin
      if ($urandom_range(0, 34) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          wv = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'sd127 : -8'sd128)
                                           : WV_W'($urandom_range(0, 255));
          queue_beat(KIND_WEIGHT, IDX_W'($urandom_range(0, 15)), wv,
                     PIX_W'($urandom_range(0, 255)));
        end
      end
      queue_beat(KIND_PIXEL, IDX_W'($urandom_range(0, 15)), WV_W'($urandom_range(0, 255)),
                 pick_pixel());
      if (pix_queued == DRAIN_AT_A || pix_queued == DRAIN_AT_B) queue_drain_pause();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last beat to be taken and every result to come back,
    // then give the pipeline a few more cycles to show any stray result.
    while (feed_q.size() != 0 || have_next || in_if.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_conv2d_valid_fixed_weights: done, clean");
    end else begin
      $display("tb_conv2d_valid_fixed_weights: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_conv2d_valid_fixed_weights: done, errors");
    $finish;
  end

endmodule
